// ----- hdl/gne_pkg.sv -----
// gne_pkg: shared constants, codes, types and direction tables for the grid neighbor expander.
// Used by gne_locate and grid_neighbor_expander_core; depends on nothing.

package gne_pkg;

   localparam int GRID_COLS_DEF = 64;
   localparam int GRID_ROWS_DEF = 64;

   localparam logic [15:0] COST_ONE = 16'd256;

   // action codes
   localparam logic [1:0] ACT_WRITE  = 2'd0;
   localparam logic [1:0] ACT_READ   = 2'd1;
   localparam logic [1:0] ACT_EXPAND = 2'd2;

   // csr register indexes
   localparam logic [2:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [2:0] CSR_GRID_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_GRID_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_DIAG_EN     = 3'd4;
   localparam logic [2:0] CSR_CORNER_EN   = 3'd5;

   // probes 0..7 are the eight directions, probe 8 the tile itself
   localparam logic [3:0] PROBE_CENTER = 4'd8;
   localparam logic [3:0] PROBE_LAST_ORTHO = 4'd3;
   localparam logic [3:0] PROBE_LAST_ALL = 4'd8;

   typedef struct packed {
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [6:0]  grid_width;
      logic [6:0]  grid_height;
   } cfg_type;

   function automatic logic signed [15:0] step_dx(input logic [3:0] p);
      logic signed [15:0] r;
      case (p)
         4'd0: r = 16'sd1;
         4'd1: r = 16'sd0;
         4'd2: r = -16'sd1;
         4'd3: r = 16'sd0;
         4'd4: r = 16'sd1;
         4'd5: r = -16'sd1;
         4'd6: r = -16'sd1;
         4'd7: r = 16'sd1;
         default: r = 16'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] step_dy(input logic [3:0] p);
      logic signed [15:0] r;
      case (p)
         4'd0: r = 16'sd0;
         4'd1: r = -16'sd1;
         4'd2: r = 16'sd0;
         4'd3: r = 16'sd1;
         4'd4: r = 16'sd1;
         4'd5: r = -16'sd1;
         4'd6: r = 16'sd1;
         4'd7: r = -16'sd1;
         default: r = 16'sd0;
      endcase
      return r;
   endfunction

   // probe that holds cell (x+dx, y)
   function automatic logic [3:0] corner_x_probe(input logic [3:0] p);
      logic signed [15:0] dx;
      logic [3:0] r;
      dx = step_dx(p);
      if (dx == 16'sd1) begin
         r = 4'd0;
      end else if (dx == -16'sd1) begin
         r = 4'd2;
      end else begin
         r = PROBE_CENTER;
      end
      return r;
   endfunction

   // probe that holds cell (x, y+dy)
   function automatic logic [3:0] corner_y_probe(input logic [3:0] p);
      logic signed [15:0] dy;
      logic [3:0] r;
      dy = step_dy(p);
      if (dy == -16'sd1) begin
         r = 4'd1;
      end else if (dy == 16'sd1) begin
         r = 4'd3;
      end else begin
         r = PROBE_CENTER;
      end
      return r;
   endfunction

endpackage

// ----- hdl/grid_neighbor_expander_core.sv -----
// grid_neighbor_expander_core: cost grid with write, read and 4/8-connected neighbor expansion.
// Depends on gne_pkg and gne_locate.
//
// The block holds GRID_COLS x GRID_ROWS signed Q8.8 costs in one single-port-read synchronous
// memory. After reset it sweeps the memory to cost 1.0, one cell per cycle, while req_ready
// stays low; csr writes are taken throughout. One request is in work at a time, and the
// memory read port loads one cell per cycle: a read loads the tile itself, an expansion with
// diagonals off its four orthogonal neighbors and with diagonals on all nine cells of the
// 3x3 neighborhood, after which the directions are checked one by one. Each result beat
// leaves through an output register, so a stalled rsp side holds the walk; the next request
// is taken as soon as the last beat of the current one is issued.

module grid_neighbor_expander_core #(
   parameter int GRID_COLS = gne_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = gne_pkg::GRID_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic signed [15:0] req_tile_x,
   input  logic signed [15:0] req_tile_y,
   input  logic signed [15:0] req_cost_in,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_cost_out,
   output logic               rsp_refused,
   output logic               rsp_last
);

   localparam int DEPTH  = GRID_COLS * GRID_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int NB     = 9;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_WRITE = 6'b000100,
      ST_LOAD  = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   gne_pkg::cfg_type cfg_ff;
   logic diag_ff;
   logic corner_ff;

   logic [1:0]  act_ff, act_in;
   logic [15:0] tile_x_ff, tile_x_in;
   logic [15:0] tile_y_ff, tile_y_in;
   logic [15:0] cost_in_ff, cost_in_in;
   logic [3:0]  p_ff, p_in;
   logic [3:0]  p_end_ff, p_end_in;
   logic [2:0]  e_ff, e_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   logic        cap_v_ff, cap_v_in;
   logic [3:0]  cap_idx_ff;
   logic        cap_in_ff;

   logic [15:0] mem [DEPTH];
   logic [15:0] rd_data_ff;
   logic        rd_en;
   logic        mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [15:0] mem_wdata;

   logic [15:0] nb_cost_ff [NB];
   logic        nb_in_ff   [NB];

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [15:0] rsp_x_ff, rsp_x_in;
   logic [15:0] rsp_y_ff, rsp_y_in;
   logic [15:0] rsp_cost_ff, rsp_cost_in;
   logic        rsp_refused_ff, rsp_refused_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [15:0] probe_x;
   logic [15:0] probe_y;
   logic        loc_inside;
   logic [ADDR_W-1:0] loc_addr;
   logic        slot_free;
   logic        corner_chk;
   logic [7:0]  ok_vec;
   logic        later_any;
   logic [3:0]  e_probe;

   assign probe_x = tile_x_ff + gne_pkg::step_dx(p_ff);
   assign probe_y = tile_y_ff + gne_pkg::step_dy(p_ff);

   gne_locate #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS),
      .ADDR_W    (ADDR_W)
   ) u_locate (
      .cfg     (cfg_ff),
      .pos_x   (probe_x),
      .pos_y   (probe_y),
      .in_grid (loc_inside),
      .addr    (loc_addr)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.grid_width  <= 7'd64;
         cfg_ff.grid_height <= 7'd64;
         diag_ff            <= 1'b0;
         corner_ff          <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            gne_pkg::CSR_ORIGIN_X:    cfg_ff.origin_x    <= csr_wdata;
            gne_pkg::CSR_ORIGIN_Y:    cfg_ff.origin_y    <= csr_wdata;
            gne_pkg::CSR_GRID_WIDTH:  cfg_ff.grid_width  <= csr_wdata[6:0];
            gne_pkg::CSR_GRID_HEIGHT: cfg_ff.grid_height <= csr_wdata[6:0];
            gne_pkg::CSR_DIAG_EN:     diag_ff            <= csr_wdata[0];
            gne_pkg::CSR_CORNER_EN:   corner_ff          <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // cost memory
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_ff : loc_addr;
   assign mem_wdata = (state_ff == ST_CLEAR) ? gne_pkg::COST_ONE : cost_in_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[loc_addr];
      end
   end

   // neighborhood capture; outside cells read as cost one
   always_ff @(posedge clock) begin
      cap_idx_ff <= p_ff;
      cap_in_ff  <= loc_inside;
      if (cap_v_ff) begin
         nb_cost_ff[cap_idx_ff] <= cap_in_ff ? rd_data_ff : gne_pkg::COST_ONE;
         nb_in_ff[cap_idx_ff]   <= cap_in_ff;
      end
   end

   assign corner_chk = diag_ff && !corner_ff;

   always_comb begin
      for (int d = 0; d < 8; d++) begin
         ok_vec[d] = ((d < 4) || diag_ff)
                  && nb_in_ff[d]
                  && !nb_cost_ff[d][15]
                  && !(corner_chk
                       && (nb_cost_ff[gne_pkg::corner_x_probe(4'(d))][15]
                           || nb_cost_ff[gne_pkg::corner_y_probe(4'(d))][15]));
      end
   end

   assign later_any = |(ok_vec & ~((8'd2 << e_ff) - 8'd1));
   assign e_probe   = {1'b0, e_ff};
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      tile_x_in      = tile_x_ff;
      tile_y_in      = tile_y_ff;
      cost_in_in     = cost_in_ff;
      p_in           = p_ff;
      p_end_in       = p_end_ff;
      e_in           = e_ff;
      clr_in         = clr_ff;
      cap_v_in       = 1'b0;
      rd_en          = 1'b0;
      mem_we         = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_found_in   = rsp_found_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_cost_in    = rsp_cost_ff;
      rsp_refused_in = rsp_refused_ff;
      rsp_last_in    = rsp_last_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               act_in     = req_action;
               tile_x_in  = req_tile_x;
               tile_y_in  = req_tile_y;
               cost_in_in = req_cost_in;
               e_in       = '0;
               case (req_action)
                  gne_pkg::ACT_WRITE: begin
                     p_in     = gne_pkg::PROBE_CENTER;
                     state_in = ST_WRITE;
                  end
                  gne_pkg::ACT_READ: begin
                     p_in     = gne_pkg::PROBE_CENTER;
                     p_end_in = gne_pkg::PROBE_CENTER;
                     state_in = ST_LOAD;
                  end
                  gne_pkg::ACT_EXPAND: begin
                     p_in     = '0;
                     p_end_in = diag_ff ? gne_pkg::PROBE_LAST_ALL : gne_pkg::PROBE_LAST_ORTHO;
                     state_in = ST_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         ST_WRITE: begin
            if (slot_free) begin
               mem_we         = loc_inside;
               rsp_valid_in   = 1'b1;
               rsp_found_in   = 1'b0;
               rsp_x_in       = tile_x_ff;
               rsp_y_in       = tile_y_ff;
               rsp_cost_in    = '0;
               rsp_refused_in = !loc_inside;
               rsp_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_LOAD: begin
            rd_en    = 1'b1;
            cap_v_in = 1'b1;
            if (p_ff == p_end_ff) begin
               state_in = ST_DRAIN;
            end else begin
               p_in = p_ff + 4'd1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (act_ff == gne_pkg::ACT_READ) begin
               if (slot_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_found_in   = 1'b1;
                  rsp_x_in       = tile_x_ff;
                  rsp_y_in       = tile_y_ff;
                  rsp_cost_in    = nb_cost_ff[gne_pkg::PROBE_CENTER];
                  rsp_refused_in = 1'b0;
                  rsp_last_in    = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (ok_vec == 8'd0) begin
               if (slot_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_found_in   = 1'b0;
                  rsp_x_in       = tile_x_ff;
                  rsp_y_in       = tile_y_ff;
                  rsp_cost_in    = '0;
                  rsp_refused_in = 1'b0;
                  rsp_last_in    = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (ok_vec[e_ff]) begin
               if (slot_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_found_in   = 1'b1;
                  rsp_x_in       = tile_x_ff + gne_pkg::step_dx(e_probe);
                  rsp_y_in       = tile_y_ff + gne_pkg::step_dy(e_probe);
                  rsp_cost_in    = nb_cost_ff[e_probe];
                  rsp_refused_in = 1'b0;
                  rsp_last_in    = !later_any;
                  if (later_any) begin
                     e_in = e_ff + 3'd1;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               e_in = e_ff + 3'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cap_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cap_v_ff     <= cap_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      act_ff         <= act_in;
      tile_x_ff      <= tile_x_in;
      tile_y_ff      <= tile_y_in;
      cost_in_ff     <= cost_in_in;
      p_ff           <= p_in;
      p_end_ff       <= p_end_in;
      e_ff           <= e_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_cost_ff    <= rsp_cost_in;
      rsp_refused_ff <= rsp_refused_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_out_x    = rsp_x_ff;
   assign rsp_out_y    = rsp_y_ff;
   assign rsp_cost_out = rsp_cost_ff;
   assign rsp_refused  = rsp_refused_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ----- hdl/gne_locate.sv -----
// gne_locate: maps a grid coordinate to a cost memory address and flags whether it lies in the grid.
// Depends on gne_pkg (cfg_type).

module gne_locate #(
   parameter int GRID_COLS = gne_pkg::GRID_COLS_DEF,
   parameter int GRID_ROWS = gne_pkg::GRID_ROWS_DEF,
   parameter int ADDR_W    = $clog2(GRID_COLS * GRID_ROWS)
) (
   input  gne_pkg::cfg_type    cfg,
   input  logic [15:0]         pos_x,
   input  logic [15:0]         pos_y,
   output logic                in_grid,
   output logic [ADDR_W-1:0]   addr
);

   localparam int COL_AW = $clog2(GRID_COLS);
   localparam int ROW_AW = $clog2(GRID_ROWS);

   logic [15:0]       ox;
   logic [15:0]       oy;
   logic              in_x;
   logic              in_y;
   logic [ADDR_W-1:0] idx;

   assign ox = pos_x - cfg.origin_x;
   assign oy = pos_y - cfg.origin_y;

   assign in_x = (ox < {9'd0, cfg.grid_width}) && (32'(ox) < GRID_COLS);
   assign in_y = (oy < {9'd0, cfg.grid_height}) && (32'(oy) < GRID_ROWS);
   assign in_grid = in_x && in_y;

   assign idx = ADDR_W'(ADDR_W'(oy[ROW_AW-1:0]) * ADDR_W'(GRID_COLS))
              + ADDR_W'(ox[COL_AW-1:0]);
   assign addr = in_grid ? idx : '0;

endmodule
